[sv/gregorian_date_day_arithmetic_core_assert.svh]
// Assertion macros for the Gregorian date arithmetic core.
// Plain SystemVerilog, no dependencies; included by the top level.
`ifndef GREGORIAN_DATE_DAY_ARITHMETIC_CORE_ASSERT_SVH
`define GREGORIAN_DATE_DAY_ARITHMETIC_CORE_ASSERT_SVH

// Check cons in the same cycle as ante.
`define GDDA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define GDDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/gdda_pkg.sv]
// Types, calendar constants and per-date helper functions for the
// Gregorian date arithmetic core. No dependencies.
package gdda_pkg;

    localparam int unsigned NSTG = 12;

    localparam logic [8:0]  YEAR_DAYS  = 9'd365;
    localparam logic [8:0]  YEAR0_DAYS = 9'd366;
    localparam int unsigned D4   = 1461;
    localparam int unsigned D100 = 36524;
    localparam int unsigned D400 = 146097;
    localparam logic [13:0] MAX_YEAR   = 14'd9999;
    localparam logic [3:0]  LAST_MONTH = 4'd12;
    localparam logic [4:0]  LAST_DAY   = 5'd31;
    // first count whose year lies past the last representable year
    localparam logic [24:0] SAT_COUNT  = 25'd3652426;

    // reciprocals for exact division by constants over the operand ranges used
    localparam int unsigned K100 = 19;
    localparam logic [12:0] M100 = 13'(((64'd1 << K100) + 64'd99) / 64'd100);
    localparam int unsigned K400 = 40;
    localparam logic [22:0] M400 =
        23'(((64'd1 << K400) + 64'(D400) - 64'd1) / 64'(D400));
    localparam int unsigned K4 = 28;
    localparam logic [17:0] M1461 =
        18'(((64'd1 << K4) + 64'(D4) - 64'd1) / 64'(D4));

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  mi;
        logic [4:0]  day;
        logic [7:0]  qp100;
        logic [5:0]  qp400;
        logic [7:0]  qy100;
    } date0_t;

    typedef struct packed {
        logic [22:0] dby;
        logic [8:0]  part;
        logic        leap_add;
    } date1_t;

    typedef struct packed {
        logic        npos;
        logic        sat;
        logic        yr0;
        logic [8:0]  doy0;
        logic [23:0] ser;
    } side_t;

    function automatic logic [8:0] days_before_month(input logic [3:0] mi);
        logic [8:0] r;
        case (mi)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd59;
            4'd3:    r = 9'd90;
            4'd4:    r = 9'd120;
            4'd5:    r = 9'd151;
            4'd6:    r = 9'd181;
            4'd7:    r = 9'd212;
            4'd8:    r = 9'd243;
            4'd9:    r = 9'd273;
            4'd10:   r = 9'd304;
            4'd11:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [8:0] month_start(input logic [3:0] mi, input logic leap);
        return days_before_month(mi) + 9'(leap && (mi >= 4'd2));
    endfunction

    // clamp the month and form the century quotients
    function automatic date0_t date_split(input logic [13:0] y, input logic [3:0] m,
                                          input logic [4:0] d);
        date0_t r;
        logic [13:0] p;
        logic [26:0] pp;
        logic [24:0] pq;
        logic [26:0] py;
        p  = y - 14'd1;
        pp = 27'(p) * 27'(M100);
        pq = 25'(p[13:2]) * 25'(M100);
        py = 27'(y) * 27'(M100);
        r.year = y;
        if (m == 4'd0) begin
            r.mi = 4'd0;
        end else if (m > LAST_MONTH) begin
            r.mi = 4'd11;
        end else begin
            r.mi = m - 4'd1;
        end
        r.day   = d;
        r.qp100 = pp[K100 +: 8];
        r.qp400 = pq[K100 +: 6];
        r.qy100 = py[K100 +: 8];
        return r;
    endfunction

    // days before the year, leap flag and the in-year part of the serial
    function automatic date1_t date_base(input date0_t a);
        date1_t r;
        logic [13:0] p;
        logic [13:0] r100;
        logic leap;
        p    = a.year - 14'd1;
        r100 = a.year - 14'(a.qy100) * 14'd100;
        leap = ((a.year[1:0] == 2'd0) && (r100 != 14'd0)) ||
               ((r100 == 14'd0) && (a.qy100[1:0] == 2'd0));
        if (a.year == 14'd0) begin
            r.dby = 23'd0;
        end else begin
            r.dby = 23'(a.year) * 23'(YEAR_DAYS) + 23'(p[13:2]) - 23'(a.qp100)
                  + 23'(a.qp400) + 23'd1;
        end
        r.part     = days_before_month(a.mi) + 9'(a.day);
        r.leap_add = leap && (a.mi >= 4'd2);
        return r;
    endfunction

    function automatic logic [22:0] date_serial(input date1_t a);
        return a.dby + 23'(a.part) + 23'(a.leap_add);
    endfunction

endpackage

[sv/gregorian_date_day_arithmetic_core.sv]
// Channel  Ports                          Word
// -------  -----------------------------  ------------------------------------------
// input    s_valid / s_ready / s_*        command, two dates, day offset
// output   m_valid / m_ready / m_*        date, serial count, invalid flag
//
// Twelve-stage pipeline: one word per cycle unless a full pipeline waits on m_ready.
// The depth is set by the two reciprocal multiplies (400-year and 4-year cycles),
// each followed by a remainder stage, plus the month search at the end.
// aresetn (synchronous) clears the stage valid bits; payload registers are not reset.
// A stage loads whenever it is empty or the stage after it moves, so bubbles close up
// and s_ready stays high while any stage is free, also when a result waits on m_ready.
// Depends on gdda_pkg and gregorian_date_day_arithmetic_core_assert.svh.
`include "gregorian_date_day_arithmetic_core_assert.svh"

module gregorian_date_day_arithmetic_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic [13:0]        s_first_year,
    input  logic [3:0]         s_first_month,
    input  logic [4:0]         s_first_day,
    input  logic [13:0]        s_second_year,
    input  logic [3:0]         s_second_month,
    input  logic [4:0]         s_second_day,
    input  logic [21:0]        s_day_offset,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [13:0]        m_out_year,
    output logic [3:0]         m_out_month,
    output logic [4:0]         m_out_day,
    output logic signed [23:0] m_serial_count,
    output logic               m_invalid
);
    import gdda_pkg::*;

    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] en;

    // stage 0: month clamp and century quotients
    logic        cmd0_reg;
    logic [21:0] off0_reg;
    date0_t      da0_reg, db0_reg;
    // stage 1: days before year and in-year part
    logic        cmd1_reg;
    logic [21:0] off1_reg;
    date1_t      da1_reg, db1_reg;
    // stage 2: serials
    logic        cmd2_reg;
    logic [21:0] off2_reg;
    logic [22:0] sa2_reg, sb2_reg;
    // stage 3: signed count
    logic [24:0] cnt3_reg;
    // stage 4: flags and day index past year 0
    side_t       sd4_reg;
    logic [21:0] w4_reg;
    side_t       sd4_next;
    logic [21:0] w4_next;
    logic [24:0] zc4, wc4;
    // stage 5: 400-year product
    side_t       sd5_reg;
    logic [21:0] w5_reg;
    logic [44:0] p5_reg;
    // stage 6: 400-year quotient and remainder
    side_t       sd6_reg;
    logic [4:0]  n400_6_reg;
    logic [17:0] r6_reg;
    logic [4:0]  n400_6_next;
    logic [21:0] rem6;
    // stage 7: centuries
    side_t       sd7_reg;
    logic [4:0]  n400_7_reg;
    logic [1:0]  n100_7_reg;
    logic [15:0] r7_reg;
    logic [1:0]  n100_7_next;
    logic [17:0] rem7;
    // stage 8: 4-year product
    side_t       sd8_reg;
    logic [4:0]  n400_8_reg;
    logic [1:0]  n100_8_reg;
    logic [15:0] r8_reg;
    logic [33:0] p8_reg;
    // stage 9: 4-year quotient and remainder
    side_t       sd9_reg;
    logic [6:0]  nc9_reg;
    logic [4:0]  n4_9_reg;
    logic [10:0] r9_reg;
    logic [4:0]  n4_9_next;
    logic [15:0] rem9;
    // stage 10: year, day of year, leap
    side_t       sd10_reg;
    logic [13:0] year10_reg;
    logic [8:0]  doy10_reg;
    logic        leap10_reg;
    logic [13:0] year10_next;
    logic [8:0]  doy10_next;
    logic        leap10_next;
    logic [1:0]  n1_10;
    logic [10:0] rem10;
    // stage 11: output word
    logic [13:0] oyear_reg, oyear_next;
    logic [3:0]  omonth_reg, omonth_next;
    logic [4:0]  oday_reg, oday_next;
    logic [23:0] oser_reg;
    logic        oinv_reg, oinv_next;
    logic [3:0]  midx11;
    logic [8:0]  dayoff11;

    // a stage moves when it or any stage after it has room
    for (genvar k = 0; k < NSTG; k++) begin : g_en
        assign en[k] = m_ready || !(&v_reg[NSTG-1:k]);
    end

    assign s_ready = en[0];
    assign m_valid = v_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            cmd0_reg <= s_command;
            off0_reg <= s_day_offset;
            da0_reg  <= date_split(s_first_year, s_first_month, s_first_day);
            db0_reg  <= date_split(s_second_year, s_second_month, s_second_day);
        end
        if (en[1]) begin
            cmd1_reg <= cmd0_reg;
            off1_reg <= off0_reg;
            da1_reg  <= date_base(da0_reg);
            db1_reg  <= date_base(db0_reg);
        end
        if (en[2]) begin
            cmd2_reg <= cmd1_reg;
            off2_reg <= off1_reg;
            sa2_reg  <= date_serial(da1_reg);
            sb2_reg  <= date_serial(db1_reg);
        end
        if (en[3]) begin
            // two's complement over 25 bits; the true range always fits
            cnt3_reg <= cmd2_reg ? ({2'b00, sa2_reg} - {2'b00, sb2_reg})
                                 : ({2'b00, sa2_reg} + {3'b000, off2_reg});
        end
    end

    always_comb begin
        zc4 = cnt3_reg - 25'd1;
        wc4 = cnt3_reg - 25'(YEAR0_DAYS) - 25'd1;
        sd4_next.npos = cnt3_reg[24] || (cnt3_reg == 25'd0);
        sd4_next.sat  = !cnt3_reg[24] && (cnt3_reg >= SAT_COUNT);
        sd4_next.yr0  = cnt3_reg[23:0] <= 24'(YEAR0_DAYS);
        sd4_next.doy0 = zc4[8:0];
        sd4_next.ser  = cnt3_reg[23:0];
        w4_next       = wc4[21:0];
    end

    always_comb begin
        n400_6_next = p5_reg[K400 +: 5];
        rem6        = w5_reg - 22'(n400_6_next) * 22'(D400);
    end

    always_comb begin
        if (r6_reg >= 18'(3 * D100)) begin
            n100_7_next = 2'd3;
        end else if (r6_reg >= 18'(2 * D100)) begin
            n100_7_next = 2'd2;
        end else if (r6_reg >= 18'(D100)) begin
            n100_7_next = 2'd1;
        end else begin
            n100_7_next = 2'd0;
        end
        rem7 = r6_reg - 18'(n100_7_next) * 18'(D100);
    end

    always_comb begin
        n4_9_next = p8_reg[K4 +: 5];
        rem9      = r8_reg - 16'(n4_9_next) * 16'(D4);
    end

    always_comb begin
        if (r9_reg >= 11'(3 * YEAR_DAYS)) begin
            n1_10 = 2'd3;
        end else if (r9_reg >= 11'(2 * YEAR_DAYS)) begin
            n1_10 = 2'd2;
        end else if (r9_reg >= 11'(YEAR_DAYS)) begin
            n1_10 = 2'd1;
        end else begin
            n1_10 = 2'd0;
        end
        rem10 = r9_reg - 11'(n1_10) * 11'(YEAR_DAYS);
        if (sd9_reg.yr0) begin
            year10_next = 14'd0;
            doy10_next  = sd9_reg.doy0;
            leap10_next = 1'b1;
        end else begin
            year10_next = 14'(nc9_reg) * 14'd100 + 14'({n4_9_reg, n1_10}) + 14'd1;
            doy10_next  = rem10[8:0];
            leap10_next = (n1_10 == 2'd3) && ((n4_9_reg != 5'd24) || (nc9_reg[1:0] == 2'd3));
        end
    end

    always_comb begin
        midx11 = 4'd0;
        for (int k = 1; k < 12; k++) begin
            if (doy10_reg >= month_start(4'(k), leap10_reg)) begin
                midx11 = 4'(k);
            end
        end
        dayoff11 = doy10_reg - month_start(midx11, leap10_reg) + 9'd1;
        if (sd10_reg.npos) begin
            oyear_next  = 14'd0;
            omonth_next = 4'd0;
            oday_next   = 5'd0;
            oinv_next   = 1'b1;
        end else if (sd10_reg.sat) begin
            oyear_next  = MAX_YEAR;
            omonth_next = LAST_MONTH;
            oday_next   = LAST_DAY;
            oinv_next   = 1'b1;
        end else begin
            oyear_next  = year10_reg;
            omonth_next = midx11 + 4'd1;
            oday_next   = dayoff11[4:0];
            oinv_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            sd4_reg <= sd4_next;
            w4_reg  <= w4_next;
        end
        if (en[5]) begin
            sd5_reg <= sd4_reg;
            w5_reg  <= w4_reg;
            p5_reg  <= 45'(w4_reg) * 45'(M400);
        end
        if (en[6]) begin
            sd6_reg    <= sd5_reg;
            n400_6_reg <= n400_6_next;
            r6_reg     <= rem6[17:0];
        end
        if (en[7]) begin
            sd7_reg    <= sd6_reg;
            n400_7_reg <= n400_6_reg;
            n100_7_reg <= n100_7_next;
            r7_reg     <= rem7[15:0];
        end
        if (en[8]) begin
            sd8_reg    <= sd7_reg;
            n400_8_reg <= n400_7_reg;
            n100_8_reg <= n100_7_reg;
            r8_reg     <= r7_reg;
            p8_reg     <= 34'(r7_reg) * 34'(M1461);
        end
        if (en[9]) begin
            sd9_reg  <= sd8_reg;
            nc9_reg  <= {n400_8_reg, n100_8_reg};
            n4_9_reg <= n4_9_next;
            r9_reg   <= rem9[10:0];
        end
        if (en[10]) begin
            sd10_reg   <= sd9_reg;
            year10_reg <= year10_next;
            doy10_reg  <= doy10_next;
            leap10_reg <= leap10_next;
        end
        if (en[11]) begin
            oyear_reg  <= oyear_next;
            omonth_reg <= omonth_next;
            oday_reg   <= oday_next;
            oser_reg   <= sd10_reg.ser;
            oinv_reg   <= oinv_next;
        end
    end

    assign m_out_year     = oyear_reg;
    assign m_out_month    = omonth_reg;
    assign m_out_day      = oday_reg;
    assign m_serial_count = $signed(oser_reg);
    assign m_invalid      = oinv_reg;

    `GDDA_ASSERT_NOW(a_valid_date_range, aclk, aresetn, (m_valid && !m_invalid),
        (m_out_year <= MAX_YEAR && m_out_month >= 4'd1 && m_out_month <= LAST_MONTH
         && m_out_day >= 5'd1 && m_out_day <= LAST_DAY),
        "valid result carries a date out of range")
    `GDDA_ASSERT_NOW(a_nonpos_zero_date, aclk, aresetn, (m_valid && m_invalid && m_out_month == 4'd0),
        (m_out_year == 14'd0 && m_out_day == 5'd0),
        "non-positive count must give an all-zero date")
    `GDDA_ASSERT_NEXT(a_accept_enters, aclk, aresetn, (s_valid && s_ready), v_reg[0],
        "accepted word did not enter the first stage")

endmodule
